/* rtl/omni_tc_pkg.sv */
// ----------------------------------------------------------------------------
// omni_tc_pkg
// shared widths, types, register indexes and helpers for the omni base
// torque control unit
// ----------------------------------------------------------------------------
`default_nettype none

package omni_tc_pkg;

    localparam int SpeedW   = 16;
    localparam int TorqueW  = 24;
    localparam int CoefW    = 16;
    localparam int GainW    = 16;
    localparam int RowW     = 3 * CoefW;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = RowW;
    localparam int InDataW  = 6 * SpeedW;
    localparam int OutDataW = 3 * TorqueW + 3 * SpeedW;

    // pipeline arithmetic widths
    localparam int Prod1W = 2 * SpeedW;          // J * speed
    localparam int Sum1W  = Prod1W + 1;          // three products
    localparam int ErrW   = SpeedW + 1;
    localparam int ForceW = GainW + ErrW;        // |f| < 2^32
    localparam int Prod2W = CoefW + ForceW - 1;  // |J * f| < 2^47
    localparam int Sum2W  = Prod2W + 2;
    localparam int NumStages = 7;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KIN_ROW_X   = 3'd0,
        REG_KIN_ROW_Y   = 3'd1,
        REG_KIN_ROW_W   = 3'd2,
        REG_FORCE_GAIN  = 3'd3,
        REG_TORQUE_GAIN = 3'd4
    } cfg_index_t;

    typedef logic signed [SpeedW-1:0]  speed_t;
    typedef logic signed [TorqueW-1:0] torque_t;
    typedef logic signed [CoefW-1:0]   coef_t;
    typedef logic signed [ErrW-1:0]    err_t;
    typedef logic signed [ForceW-1:0]  force_t;
    typedef logic signed [Prod1W-1:0]  prod1_t;
    typedef logic signed [Sum1W-1:0]   sum1_t;
    typedef logic signed [Prod2W-1:0]  prod2_t;
    typedef logic signed [Sum2W-1:0]   sum2_t;

    // coefficient j of a packed kinematic row
    function automatic coef_t coef(input logic [RowW-1:0] row, input logic [1:0] j);
        coef_t c;
        c = '0;
        case (j)
            2'd0:    c = row[CoefW-1:0];
            2'd1:    c = row[2*CoefW-1:CoefW];
            2'd2:    c = row[3*CoefW-1:2*CoefW];
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/omni_base_torque_control_unit.sv */
// ----------------------------------------------------------------------------
// omni_base_torque_control_unit
// three-wheel omni base: wheel speeds to body velocity, proportional body
// force control, forces mapped back to wheel torques
// ----------------------------------------------------------------------------
// seven-stage pipeline, one item in and one result out per cycle while the
// output does not stall. stages: wheel products, row sums, round/saturate/
// error, gain multiply, transpose products, column sums, round/saturate.
// each stage holds its item when the next one cannot load, so a stall on
// the output collapses bubbles first and then pushes back on
// s_axis_tready. configuration is taken at any time on the cfg channel
// (cfg_ready is always high) but must only change while no item is in flight.
`default_nettype none

module omni_base_torque_control_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // tdata: wheel_speed_a, wheel_speed_b, wheel_speed_c, cmd_vx, cmd_vy, cmd_wz
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [omni_tc_pkg::InDataW-1:0]     s_axis_tdata,
    // tdata: torque_a, torque_b, torque_c, body_vx, body_vy, body_wz
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [omni_tc_pkg::OutDataW-1:0]         m_axis_tdata,
    // tuser: clipped
    output logic                                     m_axis_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [omni_tc_pkg::CfgIdxW-1:0]     cfg_index,
    input  wire logic [omni_tc_pkg::CfgDataW-1:0]    cfg_data
);

    localparam int N = omni_tc_pkg::NumStages;

    // configuration
    logic [omni_tc_pkg::RowW-1:0]  kin_row_reg [3];
    logic [omni_tc_pkg::GainW-1:0] force_gain_reg;
    logic [omni_tc_pkg::GainW-1:0] torque_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kin_row_reg[0]  <= '0;
            kin_row_reg[1]  <= '0;
            kin_row_reg[2]  <= '0;
            force_gain_reg  <= '0;
            torque_gain_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (omni_tc_pkg::cfg_index_t'(cfg_index))
                omni_tc_pkg::REG_KIN_ROW_X:   kin_row_reg[0]  <= cfg_data;
                omni_tc_pkg::REG_KIN_ROW_Y:   kin_row_reg[1]  <= cfg_data;
                omni_tc_pkg::REG_KIN_ROW_W:   kin_row_reg[2]  <= cfg_data;
                omni_tc_pkg::REG_FORCE_GAIN:
                    force_gain_reg <= cfg_data[omni_tc_pkg::GainW-1:0];
                omni_tc_pkg::REG_TORQUE_GAIN:
                    torque_gain_reg <= cfg_data[omni_tc_pkg::GainW-1:0];
                default: ;
            endcase
        end
    end

    // stage control: a stage loads when it is empty or its successor loads
    logic [N-1:0] v_reg;
    logic [N-1:0] en;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || m_axis_tready;
        for (int k = N - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // input unpacking
    omni_tc_pkg::speed_t in_w   [3];
    omni_tc_pkg::speed_t in_cmd [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            in_w[j]   = s_axis_tdata[j*omni_tc_pkg::SpeedW +: omni_tc_pkg::SpeedW];
            in_cmd[j] = s_axis_tdata[(j+3)*omni_tc_pkg::SpeedW +: omni_tc_pkg::SpeedW];
        end
    end

    // stage 0: J[r][j] * w[j]
    omni_tc_pkg::prod1_t p0_reg   [3][3];
    omni_tc_pkg::speed_t cmd0_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int r = 0; r < 3; r++)
            begin
                cmd0_reg[r] <= in_cmd[r];
                for (int j = 0; j < 3; j++)
                begin
                    p0_reg[r][j] <= omni_tc_pkg::coef(kin_row_reg[r], 2'(j)) * in_w[j];
                end
            end
        end
    end

    // stage 1: row sums
    omni_tc_pkg::sum1_t  s1_reg   [3];
    omni_tc_pkg::speed_t cmd1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int r = 0; r < 3; r++)
            begin
                cmd1_reg[r] <= cmd0_reg[r];
                s1_reg[r]   <= omni_tc_pkg::sum1_t'(p0_reg[r][0])
                             + omni_tc_pkg::sum1_t'(p0_reg[r][1])
                             + omni_tc_pkg::sum1_t'(p0_reg[r][2]);
            end
        end
    end

    // stage 2: round to Q.8, saturate, error against command
    localparam int Rnd1W = omni_tc_pkg::Sum1W + 1;

    omni_tc_pkg::speed_t body_next [3];
    omni_tc_pkg::err_t   err_next  [3];
    logic                clip2_next;
    logic signed [Rnd1W-1:0] rnd1 [3];

    always_comb
    begin
        clip2_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            rnd1[r] = (Rnd1W'(s1_reg[r]) + Rnd1W'(1 <<< 11)) >>> 12;
            if (rnd1[r] > Rnd1W'(32767))
            begin
                body_next[r] = 16'sh7fff;
                clip2_next   = 1'b1;
            end
            else if (rnd1[r] < -Rnd1W'(32768))
            begin
                body_next[r] = 16'sh8000;
                clip2_next   = 1'b1;
            end
            else
            begin
                body_next[r] = rnd1[r][omni_tc_pkg::SpeedW-1:0];
            end
            err_next[r] = omni_tc_pkg::err_t'(cmd1_reg[r])
                        - omni_tc_pkg::err_t'(body_next[r]);
        end
    end

    omni_tc_pkg::speed_t body2_reg [3];
    omni_tc_pkg::err_t   err2_reg  [3];
    logic                clip2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            body2_reg <= body_next;
            err2_reg  <= err_next;
            clip2_reg <= clip2_next;
        end
    end

    // stage 3: forces, x and y use the force gain, yaw uses the torque gain
    omni_tc_pkg::force_t f3_reg    [3];
    omni_tc_pkg::speed_t body3_reg [3];
    logic                clip3_reg;
    logic signed [omni_tc_pkg::GainW:0] gain_s [3];

    always_comb
    begin
        gain_s[0] = $signed({1'b0, force_gain_reg});
        gain_s[1] = $signed({1'b0, force_gain_reg});
        gain_s[2] = $signed({1'b0, torque_gain_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            body3_reg <= body2_reg;
            clip3_reg <= clip2_reg;
            for (int r = 0; r < 3; r++)
            begin
                f3_reg[r] <= gain_s[r] * err2_reg[r];
            end
        end
    end

    // stage 4: J[r][j] * f[r]
    omni_tc_pkg::prod2_t p4_reg    [3][3];
    omni_tc_pkg::speed_t body4_reg [3];
    logic                clip4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            body4_reg <= body3_reg;
            clip4_reg <= clip3_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p4_reg[r][j] <= omni_tc_pkg::coef(kin_row_reg[r], 2'(j)) * f3_reg[r];
                end
            end
        end
    end

    // stage 5: column sums
    omni_tc_pkg::sum2_t  s5_reg    [3];
    omni_tc_pkg::speed_t body5_reg [3];
    logic                clip5_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            body5_reg <= body4_reg;
            clip5_reg <= clip4_reg;
            for (int j = 0; j < 3; j++)
            begin
                s5_reg[j] <= omni_tc_pkg::sum2_t'(p4_reg[0][j])
                           + omni_tc_pkg::sum2_t'(p4_reg[1][j])
                           + omni_tc_pkg::sum2_t'(p4_reg[2][j]);
            end
        end
    end

    // stage 6: round Q.28 to Q.8 and saturate to 24 bits
    localparam int Rnd2W = omni_tc_pkg::Sum2W + 1;
    localparam logic signed [Rnd2W-1:0] TqMax = Rnd2W'((1 <<< 23) - 1);
    localparam logic signed [Rnd2W-1:0] TqMin = -Rnd2W'(1 <<< 23);

    omni_tc_pkg::torque_t tq_next [3];
    logic                 clip6_next;
    logic signed [Rnd2W-1:0] rnd2 [3];

    always_comb
    begin
        clip6_next = clip5_reg;
        for (int j = 0; j < 3; j++)
        begin
            rnd2[j] = (Rnd2W'(s5_reg[j]) + Rnd2W'(1 <<< 19)) >>> 20;
            if (rnd2[j] > TqMax)
            begin
                tq_next[j] = 24'sh7fffff;
                clip6_next = 1'b1;
            end
            else if (rnd2[j] < TqMin)
            begin
                tq_next[j] = 24'sh800000;
                clip6_next = 1'b1;
            end
            else
            begin
                tq_next[j] = rnd2[j][omni_tc_pkg::TorqueW-1:0];
            end
        end
    end

    omni_tc_pkg::torque_t tq6_reg   [3];
    omni_tc_pkg::speed_t  body6_reg [3];
    logic                 clip6_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            tq6_reg   <= tq_next;
            body6_reg <= body5_reg;
            clip6_reg <= clip6_next;
        end
    end

    assign m_axis_tvalid = v_reg[N-1];
    assign m_axis_tuser  = clip6_reg;
    assign m_axis_tdata  = {body6_reg[2], body6_reg[1], body6_reg[0],
                            tq6_reg[2], tq6_reg[1], tq6_reg[0]};

    // checks
    logic out_at_limit;

    always_comb
    begin
        out_at_limit = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            if (tq6_reg[j] == 24'sh7fffff || tq6_reg[j] == 24'sh800000 ||
                body6_reg[j] == 16'sh7fff || body6_reg[j] == 16'sh8000)
            begin
                out_at_limit = 1'b1;
            end
        end
    end

    a_clip_means_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> out_at_limit)
        else $error("clipped set but no output value at a limit");

    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v_reg[0])
        else $error("accepted item not in first stage");

    a_backpressure_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&v_reg) && !m_axis_tready)
        else $error("input stalled while pipeline has a bubble");

    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[N-1] && !m_axis_tready |=> v_reg[N-1] && $stable(m_axis_tdata)
                                         && $stable(clip6_reg))
        else $error("stalled result lost or changed");

endmodule

`default_nettype wire
